FILE: rtl/fwt_pkg.sv
package fwt_pkg;

   // Table geometry.
   localparam int ENTRIES = 32;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // Field widths.
   localparam int OWNER_W = 8;
   localparam int ADDR_W = 32;
   localparam int DATA_W = 32;
   localparam int DL_W = 32;
   localparam int CNT_W = 6;
   localparam int SECS_W = 32;
   localparam int NANOS_W = 30;

   // Deadline arithmetic. The quotient nanos / 1000000 is taken as
   // (nanos * ceil(2^50 / 10^6)) >> 50, exact for every 30-bit operand.
   localparam logic [DL_W-1:0] NO_DEADLINE = 32'hFFFF_FFFF;
   localparam logic [DL_W-1:0] MS_PER_SEC = 32'd1000;
   localparam int NS_RECIP_W = 31;
   localparam logic [NS_RECIP_W-1:0] NS_RECIP = 31'd1125899907;
   localparam int NS_SHIFT = 50;
   localparam int NS_PROD_W = NANOS_W + NS_RECIP_W;
   localparam int QUO_W = NS_PROD_W - NS_SHIFT;

   typedef enum logic [1:0] {
      FUNC_WAIT  = 2'd0,
      FUNC_WAKE  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      KIND_WOKEN       = 3'd0,
      KIND_SATISFIED   = 3'd1,
      KIND_WAIT        = 3'd2,
      KIND_TIMED_OUT   = 3'd3,
      KIND_WOULD_BLOCK = 3'd4,
      KIND_FULL        = 3'd5,
      KIND_WAKE_DONE   = 3'd6,
      KIND_CLEAR_DONE  = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Contents of one table entry held in the slot RAM.
   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [ADDR_W-1:0]  address;
      logic [DL_W-1:0]    deadline;
   } slot_type;

   // Port control of the slot RAM.
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      slot_type         wr_data;
   } ram_ctl_type;

endpackage

FILE: rtl/fwt_slot_ram.sv
module fwt_slot_ram (
   input  logic                clock,
   input  fwt_pkg::ram_ctl_type ctl,
   output fwt_pkg::slot_type    rd_data
);

   fwt_pkg::slot_type slot_mem_ff [fwt_pkg::ENTRIES];
   fwt_pkg::slot_type rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         slot_mem_ff[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= slot_mem_ff[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/fwt_deadline.sv
module fwt_deadline (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          timeout_given,
   input  logic [fwt_pkg::SECS_W-1:0]    timeout_seconds,
   input  logic [fwt_pkg::NANOS_W-1:0]   timeout_nanos,
   input  logic [fwt_pkg::DL_W-1:0]      now_ms,
   output logic [fwt_pkg::DL_W-1:0]      deadline
);

   logic [fwt_pkg::DL_W-1:0]      sec_prod_ff, sec_prod_in;
   logic [fwt_pkg::NS_PROD_W-1:0] ns_prod_ff, ns_prod_in;
   logic [fwt_pkg::DL_W-1:0]      now_ff;
   logic                          given_ff;
   logic [fwt_pkg::QUO_W-1:0]     ns_quo;
   logic [fwt_pkg::DL_W-1:0]      deadline_ff, deadline_in;

   // First stage: seconds to milliseconds and the reciprocal product.
   assign sec_prod_in = timeout_seconds * fwt_pkg::MS_PER_SEC;
   assign ns_prod_in = fwt_pkg::NS_PROD_W'(timeout_nanos)
                     * fwt_pkg::NS_PROD_W'(fwt_pkg::NS_RECIP);

   always_ff @(posedge clock) begin
      if (load) begin
         sec_prod_ff <= sec_prod_in;
         ns_prod_ff <= ns_prod_in;
         now_ff <= now_ms;
         given_ff <= timeout_given;
      end
   end

   // Second stage: one three-term add, wrapped to the deadline width.
   assign ns_quo = ns_prod_ff[fwt_pkg::NS_PROD_W-1:fwt_pkg::NS_SHIFT];
   assign deadline_in = given_ff
                      ? sec_prod_ff + fwt_pkg::DL_W'(ns_quo) + now_ff
                      : fwt_pkg::NO_DEADLINE;

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
   end

   assign deadline = deadline_ff;

endmodule

FILE: rtl/futex_wait_wake_table.sv
// Futex wait/wake table with ENTRIES waiter slots. Issue a command by
// raising start with the req_ fields while busy is low; the beat is
// taken at that clock edge. Every wait, wake and clear walks the table
// one entry per clock through the single read port of the slot RAM and
// keeps busy high while it runs; wake, clear and a wait that finds no
// entry of its own walk every entry, a wait that finds its entry stops
// there, and func 3 is dropped without results or busy.
// Results come out on the rsp_ ports for exactly one cycle each, marked
// by rsp_valid, at most one per cycle; the receiver cannot stall them and
// must take every beat. Woken notices of a wake carry rsp_last low; the
// final beat of every command carries rsp_last high and arrives in the
// cycle in which busy has already dropped.
module futex_wait_wake_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_func,
   input  logic [fwt_pkg::OWNER_W-1:0]   req_thread_id,
   input  logic [fwt_pkg::ADDR_W-1:0]    req_word_address,
   input  logic [fwt_pkg::DATA_W-1:0]    req_value_arg,
   input  logic [fwt_pkg::DATA_W-1:0]    req_current_value,
   input  logic                          req_timeout_given,
   input  logic [fwt_pkg::SECS_W-1:0]    req_timeout_seconds,
   input  logic [fwt_pkg::NANOS_W-1:0]   req_timeout_nanos,
   input  logic [fwt_pkg::DL_W-1:0]      req_now_ms,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_kind,
   output logic [fwt_pkg::OWNER_W-1:0]   rsp_woken_thread,
   output logic [fwt_pkg::CNT_W-1:0]     rsp_wake_count,
   output logic [fwt_pkg::DL_W-1:0]      rsp_deadline_ms,
   output logic                          rsp_last
);

   fwt_pkg::state_type state_ff, state_in;

   // Command registers.
   fwt_pkg::func_type              func_ff;
   logic [fwt_pkg::OWNER_W-1:0]    thread_ff;
   logic [fwt_pkg::ADDR_W-1:0]     addr_ff;
   logic [fwt_pkg::DATA_W-1:0]     value_ff;
   logic                           eq_ff;
   logic [fwt_pkg::DL_W-1:0]       now_ff;

   // Scan pipeline and table flags.
   logic [fwt_pkg::IDX_W-1:0]      issue_idx_ff, issue_idx_in;
   logic                           issue_live_ff, issue_live_in;
   logic [fwt_pkg::IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic                           chk_live_ff, chk_live_in;
   logic [fwt_pkg::CNT_W-1:0]      count_ff, count_in;
   logic                           free_found_ff, free_found_in;
   logic [fwt_pkg::IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [fwt_pkg::ENTRIES-1:0]    valid_ff, valid_in;
   logic [fwt_pkg::ENTRIES-1:0]    woken_ff, woken_in;

   // Result registers.
   logic                           rsp_valid_ff, rsp_valid_in;
   fwt_pkg::kind_type              rsp_kind_ff, rsp_kind_in;
   logic [fwt_pkg::OWNER_W-1:0]    rsp_thread_ff, rsp_thread_in;
   logic [fwt_pkg::CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [fwt_pkg::DL_W-1:0]       rsp_deadline_ff, rsp_deadline_in;
   logic                           rsp_last_ff, rsp_last_in;

   fwt_pkg::ram_ctl_type           ram_ctl;
   fwt_pkg::slot_type              slot;
   logic [fwt_pkg::DL_W-1:0]       new_deadline;

   logic accept;
   logic checking;
   logic cur_valid, cur_woken, owner_eq, addr_eq, under_limit;
   logic wait_hit, wake_hit, clear_hit, free_hit;

   assign busy = (state_ff != fwt_pkg::ST_IDLE);
   assign accept = start && !busy;

   fwt_slot_ram u_slot_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .rd_data (slot)
   );

   fwt_deadline u_deadline (
      .clock           (clock),
      .load            (accept),
      .timeout_given   (req_timeout_given),
      .timeout_seconds (req_timeout_seconds),
      .timeout_nanos   (req_timeout_nanos),
      .now_ms          (req_now_ms),
      .deadline        (new_deadline)
   );

   // Capture the command beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= fwt_pkg::func_type'(req_func);
         thread_ff <= req_thread_id;
         addr_ff <= req_word_address;
         value_ff <= req_value_arg;
         eq_ff <= (req_current_value == req_value_arg);
         now_ff <= req_now_ms;
      end
   end

   // Compare the entry whose RAM data arrived this cycle.
   assign checking = (state_ff == fwt_pkg::ST_SCAN) && chk_live_ff;
   assign cur_valid = valid_ff[chk_idx_ff];
   assign cur_woken = woken_ff[chk_idx_ff];
   assign owner_eq = (slot.owner == thread_ff);
   assign addr_eq = (slot.address == addr_ff);
   assign under_limit = {{(fwt_pkg::DATA_W - fwt_pkg::CNT_W){1'b0}}, count_ff} < value_ff;

   assign wait_hit = checking && (func_ff == fwt_pkg::FUNC_WAIT)
                   && cur_valid && owner_eq && addr_eq;
   assign wake_hit = checking && (func_ff == fwt_pkg::FUNC_WAKE)
                   && cur_valid && addr_eq && !cur_woken && under_limit;
   assign clear_hit = checking && (func_ff == fwt_pkg::FUNC_CLEAR)
                    && cur_valid && owner_eq;
   assign free_hit = checking && (func_ff == fwt_pkg::FUNC_WAIT)
                   && !cur_valid && !free_found_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fwt_pkg::ST_IDLE: begin
            if (accept && (fwt_pkg::func_type'(req_func) != fwt_pkg::FUNC_NONE)) begin
               state_in = fwt_pkg::ST_SCAN;
            end
         end
         fwt_pkg::ST_SCAN: begin
            if (wait_hit) begin
               state_in = fwt_pkg::ST_IDLE;
            end else if (chk_live_ff && (chk_idx_ff == fwt_pkg::LAST_IDX)) begin
               state_in = fwt_pkg::ST_DONE;
            end
         end
         fwt_pkg::ST_DONE: begin
            state_in = fwt_pkg::ST_IDLE;
         end
         default: begin
            state_in = fwt_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath, table updates and result beats.
   always_comb begin
      issue_idx_in = issue_idx_ff;
      issue_live_in = issue_live_ff;
      chk_idx_in = issue_idx_ff;
      chk_live_in = 1'b0;
      count_in = count_ff;
      free_found_in = free_found_ff;
      free_idx_in = free_idx_ff;
      valid_in = valid_ff;
      woken_in = woken_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in = fwt_pkg::KIND_WOKEN;
      rsp_thread_in = '0;
      rsp_count_in = '0;
      rsp_deadline_in = '0;
      rsp_last_in = 1'b0;
      ram_ctl.rd_en = 1'b0;
      ram_ctl.rd_addr = issue_idx_ff;
      ram_ctl.wr_en = 1'b0;
      ram_ctl.wr_addr = free_idx_ff;
      ram_ctl.wr_data.owner = thread_ff;
      ram_ctl.wr_data.address = addr_ff;
      ram_ctl.wr_data.deadline = new_deadline;

      unique case (state_ff)
         fwt_pkg::ST_IDLE: begin
            if (accept) begin
               issue_idx_in = '0;
               issue_live_in = 1'b1;
               count_in = '0;
               free_found_in = 1'b0;
            end
         end
         fwt_pkg::ST_SCAN: begin
            // Issue the next read while the previous entry is compared.
            ram_ctl.rd_en = issue_live_ff;
            chk_live_in = issue_live_ff && !wait_hit;
            if (issue_live_ff) begin
               issue_idx_in = issue_idx_ff + 1'b1;
               if (issue_idx_ff == fwt_pkg::LAST_IDX) begin
                  issue_live_in = 1'b0;
               end
            end

            // A wait that finds its own entry resolves it at once.
            if (wait_hit) begin
               rsp_valid_in = 1'b1;
               rsp_last_in = 1'b1;
               if (cur_woken) begin
                  valid_in[chk_idx_ff] = 1'b0;
                  woken_in[chk_idx_ff] = 1'b0;
                  rsp_kind_in = fwt_pkg::KIND_SATISFIED;
               end else if (slot.deadline <= now_ff) begin
                  valid_in[chk_idx_ff] = 1'b0;
                  woken_in[chk_idx_ff] = 1'b0;
                  rsp_kind_in = fwt_pkg::KIND_TIMED_OUT;
               end else begin
                  rsp_kind_in = fwt_pkg::KIND_WAIT;
                  rsp_deadline_in = slot.deadline;
               end
            end

            // Remember the lowest free entry for a later allocation.
            if (free_hit) begin
               free_found_in = 1'b1;
               free_idx_in = chk_idx_ff;
            end

            // Wake marks the entry and reports its owner.
            if (wake_hit) begin
               woken_in[chk_idx_ff] = 1'b1;
               count_in = count_ff + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in = fwt_pkg::KIND_WOKEN;
               rsp_thread_in = slot.owner;
            end

            if (clear_hit) begin
               valid_in[chk_idx_ff] = 1'b0;
               woken_in[chk_idx_ff] = 1'b0;
            end
         end
         fwt_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_last_in = 1'b1;
            case (func_ff)
               fwt_pkg::FUNC_WAIT: begin
                  if (!eq_ff) begin
                     rsp_kind_in = fwt_pkg::KIND_WOULD_BLOCK;
                  end else if (free_found_ff) begin
                     ram_ctl.wr_en = 1'b1;
                     valid_in[free_idx_ff] = 1'b1;
                     woken_in[free_idx_ff] = 1'b0;
                     rsp_kind_in = fwt_pkg::KIND_WAIT;
                     rsp_deadline_in = new_deadline;
                  end else begin
                     rsp_kind_in = fwt_pkg::KIND_FULL;
                  end
               end
               fwt_pkg::FUNC_WAKE: begin
                  rsp_kind_in = fwt_pkg::KIND_WAKE_DONE;
                  rsp_count_in = count_ff;
               end
               fwt_pkg::FUNC_CLEAR: begin
                  rsp_kind_in = fwt_pkg::KIND_CLEAR_DONE;
               end
               default: begin
                  rsp_valid_in = 1'b0;
                  rsp_last_in = 1'b0;
               end
            endcase
         end
         default: begin
            chk_live_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fwt_pkg::ST_IDLE;
         issue_live_ff <= 1'b0;
         chk_live_ff <= 1'b0;
         free_found_ff <= 1'b0;
         count_ff <= '0;
         valid_ff <= '0;
         woken_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_live_ff <= issue_live_in;
         chk_live_ff <= chk_live_in;
         free_found_ff <= free_found_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         woken_ff <= woken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Index and result payload registers.
   always_ff @(posedge clock) begin
      issue_idx_ff <= issue_idx_in;
      chk_idx_ff <= chk_idx_in;
      free_idx_ff <= free_idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_thread_ff <= rsp_thread_in;
      rsp_count_ff <= rsp_count_in;
      rsp_deadline_ff <= rsp_deadline_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_woken_thread = rsp_thread_ff;
   assign rsp_wake_count = rsp_count_ff;
   assign rsp_deadline_ms = rsp_deadline_ff;
   assign rsp_last = rsp_last_ff;

endmodule

FILE: rtl/fwt_checker.sv
module fwt_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic [1:0]                req_func,
   input logic                      rsp_valid,
   input logic [2:0]                rsp_kind,
   input logic [fwt_pkg::CNT_W-1:0] rsp_wake_count,
   input logic                      rsp_last
);

   // A real command beat always starts a table walk.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func != fwt_pkg::FUNC_NONE)) |=> busy)
      else $error("command beat did not raise busy");

   // No result beat can follow an idle cycle.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !rsp_valid)
      else $error("result beat without a command in progress");

   // Only woken notices are non-final.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != fwt_pkg::KIND_WOKEN)))
      else $error("last flag does not match result kind");

   // The final beat arrives once busy has dropped; notices come while busy.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == !busy))
      else $error("final beat and busy disagree");

   // A wake never reports more entries than the table holds.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == fwt_pkg::KIND_WAKE_DONE))
      |-> (rsp_wake_count <= fwt_pkg::CNT_W'(fwt_pkg::ENTRIES)))
      else $error("wake count exceeds table size");

endmodule

bind futex_wait_wake_table fwt_checker u_fwt_checker (.*);

FILE: bench/tb_futex_wait_wake_table.sv
`timescale 1ns / 100ps

module tb_futex_wait_wake_table;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;
   localparam int RANDOM_ITEMS = 350;
   localparam logic [29:0] NS_PER_MS = 30'd1000000;

   // One command as driven on the req_ ports.
   typedef struct {
      fwt_pkg::func_type           func;
      logic [fwt_pkg::OWNER_W-1:0] thread_id;
      logic [fwt_pkg::ADDR_W-1:0]  word_address;
      logic [fwt_pkg::DATA_W-1:0]  value_arg;
      logic [fwt_pkg::DATA_W-1:0]  current_value;
      logic                        timeout_given;
      logic [fwt_pkg::SECS_W-1:0]  timeout_seconds;
      logic [fwt_pkg::NANOS_W-1:0] timeout_nanos;
      logic [fwt_pkg::DL_W-1:0]    now_ms;
   } futex_req_type;

   // One result beat as seen on the rsp_ ports.
   typedef struct {
      fwt_pkg::kind_type           kind;
      logic [fwt_pkg::OWNER_W-1:0] woken_thread;
      logic [fwt_pkg::CNT_W-1:0]   wake_count;
      logic [fwt_pkg::DL_W-1:0]    deadline_ms;
      logic                        last;
   } futex_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic rsp_valid;
   logic [2:0] rsp_kind;
   logic [fwt_pkg::OWNER_W-1:0] rsp_woken_thread;
   logic [fwt_pkg::CNT_W-1:0] rsp_wake_count;
   logic [fwt_pkg::DL_W-1:0] rsp_deadline_ms;
   logic rsp_last;

   futex_req_type cur_req;

   // Mirror of the waiter table.
   logic                        waiter_valid [fwt_pkg::ENTRIES];
   logic [fwt_pkg::OWNER_W-1:0] waiter_owner [fwt_pkg::ENTRIES];
   logic [fwt_pkg::ADDR_W-1:0]  waiter_address [fwt_pkg::ENTRIES];
   logic [fwt_pkg::DL_W-1:0]    waiter_deadline [fwt_pkg::ENTRIES];
   logic                        waiter_woken [fwt_pkg::ENTRIES];

   futex_beat_type owed_beats[$];
   int taken_count = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   logic idle_on = 1'b1;
   logic [fwt_pkg::DL_W-1:0] sim_ms;
   logic [fwt_pkg::OWNER_W-1:0] thread_pool [10];
   logic [fwt_pkg::ADDR_W-1:0] addr_pool [6];

   futex_wait_wake_table dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (cur_req.func),
      .req_thread_id       (cur_req.thread_id),
      .req_word_address    (cur_req.word_address),
      .req_value_arg       (cur_req.value_arg),
      .req_current_value   (cur_req.current_value),
      .req_timeout_given   (cur_req.timeout_given),
      .req_timeout_seconds (cur_req.timeout_seconds),
      .req_timeout_nanos   (cur_req.timeout_nanos),
      .req_now_ms          (cur_req.now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_kind            (rsp_kind),
      .rsp_woken_thread    (rsp_woken_thread),
      .rsp_wake_count      (rsp_wake_count),
      .rsp_deadline_ms     (rsp_deadline_ms),
      .rsp_last            (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void free_waiter(input int i);
      waiter_valid[i] = 1'b0;
      waiter_owner[i] = '0;
      waiter_address[i] = '0;
      waiter_deadline[i] = '0;
      waiter_woken[i] = 1'b0;
   endfunction

   function automatic void push_beat(input fwt_pkg::kind_type kind,
                                     input logic [fwt_pkg::OWNER_W-1:0] thr,
                                     input logic [fwt_pkg::CNT_W-1:0] cnt,
                                     input logic [fwt_pkg::DL_W-1:0] dl,
                                     input logic last);
      futex_beat_type b;
      b.kind = kind;
      b.woken_thread = thr;
      b.wake_count = cnt;
      b.deadline_ms = dl;
      b.last = last;
      owed_beats.push_back(b);
   endfunction

   // Applies one command to the mirrored table and queues the beats it owes.
   function automatic void resolve_futex_op(input futex_req_type rq);
      int i;
      int hit;
      int slot;
      logic [31:0] woke;
      logic [fwt_pkg::DL_W-1:0] dl;
      hit = -1;
      slot = -1;
      woke = '0;
      case (rq.func)
         fwt_pkg::FUNC_WAIT: begin
            for (i = 0; i < fwt_pkg::ENTRIES; i++) begin
               if (hit < 0 && waiter_valid[i] && waiter_owner[i] == rq.thread_id &&
                   waiter_address[i] == rq.word_address)
                  hit = i;
            end
            if (hit >= 0) begin
               // An existing entry resolves, times out, or keeps waiting.
               if (waiter_woken[hit]) begin
                  free_waiter(hit);
                  push_beat(fwt_pkg::KIND_SATISFIED, '0, '0, '0, 1'b1);
               end else if (waiter_deadline[hit] <= rq.now_ms) begin
                  free_waiter(hit);
                  push_beat(fwt_pkg::KIND_TIMED_OUT, '0, '0, '0, 1'b1);
               end else begin
                  push_beat(fwt_pkg::KIND_WAIT, '0, '0, waiter_deadline[hit], 1'b1);
               end
            end else begin
               if (rq.timeout_given)
                  dl = rq.timeout_seconds * fwt_pkg::MS_PER_SEC +
                       32'(rq.timeout_nanos / NS_PER_MS) + rq.now_ms;
               else
                  dl = fwt_pkg::NO_DEADLINE;
               for (i = 0; i < fwt_pkg::ENTRIES; i++) begin
                  if (slot < 0 && !waiter_valid[i])
                     slot = i;
               end
               if (rq.current_value != rq.value_arg) begin
                  push_beat(fwt_pkg::KIND_WOULD_BLOCK, '0, '0, '0, 1'b1);
               end else if (slot < 0) begin
                  push_beat(fwt_pkg::KIND_FULL, '0, '0, '0, 1'b1);
               end else begin
                  waiter_valid[slot] = 1'b1;
                  waiter_owner[slot] = rq.thread_id;
                  waiter_address[slot] = rq.word_address;
                  waiter_deadline[slot] = dl;
                  waiter_woken[slot] = 1'b0;
                  push_beat(fwt_pkg::KIND_WAIT, '0, '0, dl, 1'b1);
               end
            end
         end
         fwt_pkg::FUNC_WAKE: begin
            // Mark unwoken waiters on the address in index order, up to the limit.
            for (i = 0; i < fwt_pkg::ENTRIES; i++) begin
               if (woke < rq.value_arg && waiter_valid[i] && !waiter_woken[i] &&
                   waiter_address[i] == rq.word_address) begin
                  waiter_woken[i] = 1'b1;
                  push_beat(fwt_pkg::KIND_WOKEN, waiter_owner[i], '0, '0, 1'b0);
                  woke = woke + 1;
               end
            end
            push_beat(fwt_pkg::KIND_WAKE_DONE, '0, fwt_pkg::CNT_W'(woke), '0, 1'b1);
         end
         fwt_pkg::FUNC_CLEAR: begin
            for (i = 0; i < fwt_pkg::ENTRIES; i++) begin
               if (waiter_valid[i] && waiter_owner[i] == rq.thread_id)
                  free_waiter(i);
            end
            push_beat(fwt_pkg::KIND_CLEAR_DONE, '0, '0, '0, 1'b1);
         end
         default: begin
            // The unused function code is dropped silently.
         end
      endcase
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: mismatch: %s", $realtime, msg);
   endtask

   // Check each result beat against the oldest owed beat, then record new commands.
   always @(posedge clock) begin
      futex_beat_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (owed_beats.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat kind %0d thread %0d count %0d dl %h last %b",
                                       rsp_kind, rsp_woken_thread, rsp_wake_count,
                                       rsp_deadline_ms, rsp_last));
            end else begin
               want = owed_beats.pop_front();
               if (rsp_kind !== want.kind || rsp_woken_thread !== want.woken_thread ||
                   rsp_wake_count !== want.wake_count || rsp_deadline_ms !== want.deadline_ms ||
                   rsp_last !== want.last)
                  flag_mismatch($sformatf(
                     "expected kind %0d thread %0d count %0d dl %h last %b, got %0d %0d %0d %h %b",
                     want.kind, want.woken_thread, want.wake_count, want.deadline_ms, want.last,
                     rsp_kind, rsp_woken_thread, rsp_wake_count, rsp_deadline_ms, rsp_last));
            end
         end
         if (start && !busy) begin
            resolve_futex_op(cur_req);
            taken_count++;
         end
      end
   end

   // Watchdog on cycles in which no command and no result beat moves.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("futex_wait_wake_table verification failed");
         $finish;
      end
   end

   // Drives one command from a falling edge and returns once it has been taken.
   task automatic send_cmd(input futex_req_type rq);
      int target;
      if (idle_on && $urandom_range(0, 99) < 6) begin
         start = 1'b0;
         repeat ($urandom_range(1, 40)) @(negedge clock);
      end
      cur_req = rq;
      start = 1'b1;
      target = taken_count + 1;
      while (taken_count != target)
         @(negedge clock);
   endtask

   function automatic futex_req_type wait_cmd(input logic [fwt_pkg::OWNER_W-1:0] thr,
                                              input logic [fwt_pkg::ADDR_W-1:0] addr,
                                              input logic [fwt_pkg::DATA_W-1:0] varg,
                                              input logic [fwt_pkg::DATA_W-1:0] cur,
                                              input logic tg,
                                              input logic [fwt_pkg::SECS_W-1:0] secs,
                                              input logic [fwt_pkg::NANOS_W-1:0] nanos,
                                              input logic [fwt_pkg::DL_W-1:0] now);
      futex_req_type rq;
      rq.func = fwt_pkg::FUNC_WAIT;
      rq.thread_id = thr;
      rq.word_address = addr;
      rq.value_arg = varg;
      rq.current_value = cur;
      rq.timeout_given = tg;
      rq.timeout_seconds = secs;
      rq.timeout_nanos = nanos;
      rq.now_ms = now;
      return rq;
   endfunction

   function automatic futex_req_type wake_cmd(input logic [fwt_pkg::ADDR_W-1:0] addr,
                                              input logic [fwt_pkg::DATA_W-1:0] limit);
      futex_req_type rq;
      rq = wait_cmd(8'($urandom), addr, limit, $urandom, 1'b1, $urandom, 30'($urandom), $urandom);
      rq.func = fwt_pkg::FUNC_WAKE;
      return rq;
   endfunction

   function automatic futex_req_type clear_cmd(input logic [fwt_pkg::OWNER_W-1:0] thr);
      futex_req_type rq;
      rq = wait_cmd(thr, $urandom, $urandom, $urandom, 1'b1, $urandom, 30'($urandom), $urandom);
      rq.func = fwt_pkg::FUNC_CLEAR;
      return rq;
   endfunction

   // Random command over small pools of threads and addresses so that waits
   // meet their own entries, wakes find waiters and the table fills up.
   function automatic futex_req_type random_cmd();
      futex_req_type rq;
      int pick;
      rq.thread_id = ($urandom_range(0, 19) == 0) ? 8'($urandom)
                                                  : thread_pool[$urandom_range(0, 9)];
      rq.word_address = ($urandom_range(0, 19) == 0) ? $urandom
                                                     : addr_pool[$urandom_range(0, 5)];
      rq.current_value = $urandom;
      rq.value_arg = ($urandom_range(0, 99) < 85) ? rq.current_value : $urandom;
      rq.timeout_given = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      rq.timeout_seconds = (pick < 8) ? '0 : (pick == 8) ? $urandom_range(1, 3) : $urandom;
      pick = $urandom_range(0, 9);
      rq.timeout_nanos = (pick < 7) ? 30'($urandom_range(0, 12000000))
                       : (pick < 9) ? 30'($urandom_range(0, 999999999)) : 30'($urandom);
      sim_ms = sim_ms + $urandom_range(0, 3);
      rq.now_ms = ($urandom_range(0, 9) == 0) ? $urandom : sim_ms;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         rq.func = fwt_pkg::FUNC_WAIT;
      end else if (pick < 82) begin
         rq.func = fwt_pkg::FUNC_WAKE;
         pick = $urandom_range(0, 99);
         rq.value_arg = (pick < 35) ? 32'd1 : (pick < 55) ? $urandom_range(2, 4)
                      : (pick < 70) ? '0 : (pick < 85) ? 32'hFFFF_FFFF : $urandom;
      end else if (pick < 95) begin
         rq.func = fwt_pkg::FUNC_CLEAR;
      end else begin
         rq.func = fwt_pkg::FUNC_NONE;
      end
      return rq;
   endfunction

   // Wait, repeated wait, wake limits and satisfied waits.
   task automatic test_wait_wake;
      send_cmd(wait_cmd(8'h00, 32'h0, 32'h0, 32'h0, 1'b0, '0, '0, 32'd100));
      send_cmd(wait_cmd(8'h00, 32'h0, 32'h0, 32'h0, 1'b0, '0, '0, 32'd101));
      send_cmd(wait_cmd(8'hFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd5,
                        30'd999999999, 32'd100));
      send_cmd(wake_cmd(32'h0, 32'd0));
      send_cmd(wake_cmd(32'h0, 32'd1));
      send_cmd(wake_cmd(32'h0, 32'hFFFF_FFFF));
      send_cmd(wait_cmd(8'h00, 32'h0, 32'h0, 32'h0, 1'b0, '0, '0, 32'd102));
      send_cmd(wait_cmd(8'hFF, 32'h0, 32'h0, 32'h0, 1'b0, '0, '0, 32'd102));
   endtask

   task automatic test_would_block;
      send_cmd(wait_cmd(8'h5A, 32'hDEAD_BEEC, 32'd1, 32'd2, 1'b1, 32'd1, 30'd0, 32'd5));
   endtask

   // Deadline reached exactly, the infinite deadline at the top of time, and
   // a wrapped deadline from the largest timeout fields.
   task automatic test_deadlines;
      send_cmd(wait_cmd(8'h5A, 32'hFFFF_FFFF, 32'd7, 32'd7, 1'b1, '0, 30'd3000000, 32'd1000));
      send_cmd(wait_cmd(8'h5A, 32'hFFFF_FFFF, 32'd7, 32'd7, 1'b0, '0, '0, 32'd1002));
      send_cmd(wait_cmd(8'h5A, 32'hFFFF_FFFF, 32'd7, 32'd7, 1'b0, '0, '0, 32'd1003));
      send_cmd(wait_cmd(8'h5A, 32'hDEAD_BEEC, 32'd3, 32'd3, 1'b0, '0, '0, 32'd0));
      send_cmd(wait_cmd(8'h5A, 32'hDEAD_BEEC, 32'd3, 32'd3, 1'b0, '0, '0, 32'hFFFF_FFFF));
      send_cmd(wait_cmd(8'h00, 32'hDEAD_BEEC, 32'd9, 32'd9, 1'b1, 32'hFFFF_FFFF,
                        30'h3FFF_FFFF, 32'hFFFF_FFFF));
   endtask

   task automatic test_clear;
      send_cmd(clear_cmd(8'h00));
      send_cmd(wait_cmd(8'h00, 32'hDEAD_BEEC, 32'd9, 32'd9, 1'b0, '0, '0, 32'd20));
      send_cmd(clear_cmd(8'hFF));
      send_cmd(clear_cmd(8'h00));
   endtask

   task automatic test_ignored_func;
      futex_req_type rq;
      rq = random_cmd();
      rq.func = fwt_pkg::FUNC_NONE;
      send_cmd(rq);
   endtask

   // Fill every entry on one address, overflow it, wake all in one command,
   // then let each owner collect its wakeup.
   task automatic test_table_full;
      logic [fwt_pkg::ADDR_W-1:0] addr;
      logic [fwt_pkg::DATA_W-1:0] word;
      int i;
      addr = $urandom;
      word = $urandom;
      for (i = 0; i < fwt_pkg::ENTRIES; i++)
         send_cmd(wait_cmd(8'(i * 8), addr, word, word, 1'b0, '0, '0, sim_ms));
      send_cmd(wait_cmd(8'h07, addr, word, word, 1'b0, '0, '0, sim_ms));
      send_cmd(wake_cmd(addr, 32'hFFFF_FFFF));
      for (i = 0; i < fwt_pkg::ENTRIES; i++)
         send_cmd(wait_cmd(8'(i * 8), addr, word, word, 1'b0, '0, '0, sim_ms));
   endtask

   // Mostly well-formed traffic; a stretch in the middle runs without gaps.
   task automatic test_random_traffic;
      futex_req_type rq;
      int counted;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         idle_on = !(counted >= 120 && counted < 220);
         rq = random_cmd();
         if (rq.func != fwt_pkg::FUNC_NONE)
            counted++;
         send_cmd(rq);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      int i;
      cur_req = wait_cmd('0, '0, '0, '0, 1'b0, '0, '0, '0);
      for (i = 0; i < fwt_pkg::ENTRIES; i++)
         free_waiter(i);
      thread_pool[0] = 8'h00;
      thread_pool[1] = 8'hFF;
      for (i = 2; i < 10; i++)
         thread_pool[i] = 8'($urandom);
      addr_pool[0] = 32'h0;
      addr_pool[1] = 32'hFFFF_FFFF;
      for (i = 2; i < 6; i++)
         addr_pool[i] = $urandom;
      sim_ms = $urandom_range(0, 1000);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_wait_wake();
      test_would_block();
      test_deadlines();
      test_clear();
      test_ignored_func();
      test_table_full();
      test_random_traffic();

      // Let the last beats drain before the verdict.
      start = 1'b0;
      while (owed_beats.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("futex_wait_wake_table verification clean");
      else
         $display("futex_wait_wake_table verification failed");
      $finish;
   end

endmodule
